>>> rtl/core/rgbyc_pkg.sv
// Shared types and constants for the RGB to YCbCr converter.
`timescale 1ns / 1ps

package rgbyc_pkg;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       line_start;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] luma_second;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
		logic [7:0] alpha_out;
	} result_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// one conversion job: a single pixel (second == first) or a 4:2:2 pair
	typedef struct packed {
		rgb_t       first;
		rgb_t       second;
		logic [7:0] alpha;
		logic       pair;
	} job_t;

	localparam logic [1:0] REG_COLORIMETRY = 2'd0;
	localparam logic [1:0] REG_FULL_SWING  = 2'd1;
	localparam logic [1:0] REG_CHROMA_MODE = 2'd2;

	localparam logic [1:0] CM_BT601  = 2'd0;
	localparam logic [1:0] CM_BT709  = 2'd1;
	localparam logic [1:0] CM_BT2020 = 2'd2;

	// weights times 1e4
	localparam longint WR_E4_BT601  = 2990;
	localparam longint WB_E4_BT601  = 1140;
	localparam longint WR_E4_BT709  = 2126;
	localparam longint WB_E4_BT709  = 722;
	localparam longint WR_E4_BT2020 = 2627;
	localparam longint WB_E4_BT2020 = 593;

endpackage

>>> rtl/core/rgbyc_queue.sv
// Small show-ahead FIFO used between the converter stages.
`timescale 1ns / 1ps

module rgbyc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/rgbyc_front.sv
// Input side: accepts pixels, pairs them in 4:2:2 mode and issues conversion jobs.
`timescale 1ns / 1ps

module rgbyc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rgbyc_pkg::pixel_in_t  pixel,
	output logic                  full,
	input  logic                  chroma_mode,
	input  logic                  job_full,
	output logic                  job_push,
	output rgbyc_pkg::job_t       job
);

	localparam logic PHASE_FIRST  = 1'b0;
	localparam logic PHASE_SECOND = 1'b1;

	logic            phase_q;
	rgbyc_pkg::rgb_t held_q;
	rgbyc_pkg::rgb_t cur;
	logic            accept;
	logic            hold;

	assign full   = job_full;
	assign accept = push && !job_full;
	assign cur    = '{red: pixel.red, green: pixel.green, blue: pixel.blue};
	assign hold   = chroma_mode && (pixel.line_start || phase_q == PHASE_FIRST);

	assign job_push = accept && !hold;

	always_comb begin
		job.alpha = pixel.alpha;
		if (chroma_mode) begin
			job.first  = held_q;
			job.second = cur;
			job.pair   = 1'b1;
		end else begin
			job.first  = cur;
			job.second = cur;
			job.pair   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_FIRST;
			held_q  <= '0;
		end else if (accept) begin
			if (hold) begin
				held_q  <= cur;
				phase_q <= PHASE_SECOND;
			end else begin
				phase_q <= PHASE_FIRST;
			end
		end
	end

endmodule

>>> rtl/core/rgbyc_back.sv
// Conversion pipeline: luma, chroma products, offset and clamp, range scaling.
`timescale 1ns / 1ps

module rgbyc_back #(
	parameter int FRAC_BITS = 16,
	parameter int OUT_DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          colorimetry,
	input  logic                full_swing,
	input  logic                job_valid,
	input  rgbyc_pkg::job_t     job,
	output logic                job_pop,
	input  logic                drain,
	output logic                res_push,
	output rgbyc_pkg::result_t  res
);

	localparam int WW  = FRAC_BITS + 1;
	localparam int KW  = FRAC_BITS;
	localparam int YW  = FRAC_BITS + 8;
	localparam int DW  = FRAC_BITS + 9;
	localparam int PW  = 2 * FRAC_BITS + 10;
	localparam int CW  = FRAC_BITS + 10;
	localparam int TW  = FRAC_BITS + 11;
	localparam int TCW = FRAC_BITS + 9;
	localparam int LW  = FRAC_BITS + 16;
	localparam int UW  = FRAC_BITS + 17;
	localparam int CRW = $clog2(OUT_DEPTH + 1);

	localparam longint UNIT  = longint'(1) << FRAC_BITS;
	localparam longint UNIT2 = longint'(2) << FRAC_BITS;

	localparam longint WR_601  = (rgbyc_pkg::WR_E4_BT601 * UNIT2 + 10000) / 20000;
	localparam longint WB_601  = (rgbyc_pkg::WB_E4_BT601 * UNIT2 + 10000) / 20000;
	localparam longint WG_601  = UNIT - WR_601 - WB_601;
	localparam longint WR_709  = (rgbyc_pkg::WR_E4_BT709 * UNIT2 + 10000) / 20000;
	localparam longint WB_709  = (rgbyc_pkg::WB_E4_BT709 * UNIT2 + 10000) / 20000;
	localparam longint WG_709  = UNIT - WR_709 - WB_709;
	localparam longint WR_2020 = (rgbyc_pkg::WR_E4_BT2020 * UNIT2 + 10000) / 20000;
	localparam longint WB_2020 = (rgbyc_pkg::WB_E4_BT2020 * UNIT2 + 10000) / 20000;
	localparam longint WG_2020 = UNIT - WR_2020 - WB_2020;

	localparam longint DB_601  = 10000 - rgbyc_pkg::WB_E4_BT601;
	localparam longint DR_601  = 10000 - rgbyc_pkg::WR_E4_BT601;
	localparam longint DB_709  = 10000 - rgbyc_pkg::WB_E4_BT709;
	localparam longint DR_709  = 10000 - rgbyc_pkg::WR_E4_BT709;
	localparam longint DB_2020 = 10000 - rgbyc_pkg::WB_E4_BT2020;
	localparam longint DR_2020 = 10000 - rgbyc_pkg::WR_E4_BT2020;

	localparam longint KB_601  = (5000 * UNIT2 + DB_601) / (2 * DB_601);
	localparam longint KR_601  = (5000 * UNIT2 + DR_601) / (2 * DR_601);
	localparam longint KB_709  = (5000 * UNIT2 + DB_709) / (2 * DB_709);
	localparam longint KR_709  = (5000 * UNIT2 + DR_709) / (2 * DR_709);
	localparam longint KB_2020 = (5000 * UNIT2 + DB_2020) / (2 * DB_2020);
	localparam longint KR_2020 = (5000 * UNIT2 + DR_2020) / (2 * DR_2020);

	localparam longint OFF_L = longint'(255) << FRAC_BITS;
	localparam longint TOP_L = longint'(510) << FRAC_BITS;

	// floor(x / 255), exact for quotients up to 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = 17'(x) + 17'(x[15:8]) + 17'd1;
		return s[15:8];
	endfunction

	function automatic logic [TCW-1:0] clamp_t(input logic signed [TW-1:0] t);
		logic [TCW-1:0] r;
		if (t < 0) begin
			r = '0;
		end else if (t > TW'(TOP_L)) begin
			r = TCW'(TOP_L);
		end else begin
			r = TCW'(t);
		end
		return r;
	endfunction

	logic [WW-1:0] wr_sel, wg_sel, wb_sel;
	logic [KW-1:0] kb_sel, kr_sel;

	always_comb begin
		case (colorimetry)
			rgbyc_pkg::CM_BT601: begin
				wr_sel = WW'(WR_601);
				wg_sel = WW'(WG_601);
				wb_sel = WW'(WB_601);
				kb_sel = KW'(KB_601);
				kr_sel = KW'(KR_601);
			end
			rgbyc_pkg::CM_BT2020: begin
				wr_sel = WW'(WR_2020);
				wg_sel = WW'(WG_2020);
				wb_sel = WW'(WB_2020);
				kb_sel = KW'(KB_2020);
				kr_sel = KW'(KR_2020);
			end
			default: begin
				wr_sel = WW'(WR_709);
				wg_sel = WW'(WG_709);
				wb_sel = WW'(WB_709);
				kb_sel = KW'(KB_709);
				kr_sel = KW'(KR_709);
			end
		endcase
	end

	// output queue credits
	logic [CRW-1:0] credit_q;
	logic           issue;

	assign issue   = job_valid && (credit_q != '0);
	assign job_pop = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CRW'(OUT_DEPTH);
		end else if (issue && !drain) begin
			credit_q <= credit_q - 1'b1;
		end else if (drain && !issue) begin
			credit_q <= credit_q + 1'b1;
		end
	end

	rgbyc_pkg::rgb_t lane_px [2];
	assign lane_px[0] = job.first;
	assign lane_px[1] = job.second;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic pair_s1, pair_s2, pair_s3, pair_s4, pair_s5;
	logic [7:0] alpha_s1, alpha_s2, alpha_s3, alpha_s4, alpha_s5;

	logic [YW-1:0]          ys_s1   [2];
	logic [7:0]             red_s1  [2];
	logic [7:0]             blue_s1 [2];
	logic signed [PW-1:0]   prodb_s2 [2];
	logic signed [PW-1:0]   prodr_s2 [2];
	logic [15:0]            lv_s2   [2];
	logic [7:0]             yf_s2   [2];
	logic [7:0]             y_s3    [2];
	logic [TCW-1:0]         tb_s3, tr_s3;
	logic [7:0]             y_s4    [2];
	logic [15:0]            ub_s4, ur_s4;
	logic [7:0]             fb_s4, fr_s4;
	logic [7:0]             y_s5    [2];
	logic [7:0]             cb_s5, cr_s5;

	logic signed [DW-1:0]   diffb [2];
	logic signed [DW-1:0]   diffr [2];
	logic [LW-1:0]          lprod [2];
	logic signed [CW-1:0]   cb_c  [2];
	logic signed [CW-1:0]   cr_c  [2];
	logic signed [TW-1:0]   tb_sum, tr_sum;
	logic [UW-1:0]          pb224, pr224;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			diffb[l] = $signed({1'b0, blue_s1[l], {FRAC_BITS{1'b0}}})
				- $signed({1'b0, ys_s1[l]});
			diffr[l] = $signed({1'b0, red_s1[l], {FRAC_BITS{1'b0}}})
				- $signed({1'b0, ys_s1[l]});
			lprod[l] = LW'(ys_s1[l]) * LW'(8'd219);
			cb_c[l]  = prodb_s2[l][PW-1:FRAC_BITS];
			cr_c[l]  = prodr_s2[l][PW-1:FRAC_BITS];
		end
		tb_sum = TW'(cb_c[0]) + TW'(cb_c[1]) + TW'(OFF_L);
		tr_sum = TW'(cr_c[0]) + TW'(cr_c[1]) + TW'(OFF_L);
		pb224  = UW'(tb_s3) * UW'(8'd224);
		pr224  = UW'(tr_s3) * UW'(8'd224);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		pair_s1  <= job.pair;
		alpha_s1 <= job.alpha;
		pair_s2  <= pair_s1;
		alpha_s2 <= alpha_s1;
		pair_s3  <= pair_s2;
		alpha_s3 <= alpha_s2;
		pair_s4  <= pair_s3;
		alpha_s4 <= alpha_s3;
		pair_s5  <= pair_s4;
		alpha_s5 <= alpha_s4;
		for (int l = 0; l < 2; l++) begin
			ys_s1[l] <= YW'(wr_sel) * YW'(lane_px[l].red)
				+ YW'(wg_sel) * YW'(lane_px[l].green)
				+ YW'(wb_sel) * YW'(lane_px[l].blue);
			red_s1[l]  <= lane_px[l].red;
			blue_s1[l] <= lane_px[l].blue;

			prodb_s2[l] <= PW'(diffb[l]) * PW'($signed({1'b0, kb_sel}));
			prodr_s2[l] <= PW'(diffr[l]) * PW'($signed({1'b0, kr_sel}));
			lv_s2[l]    <= lprod[l][FRAC_BITS+15:FRAC_BITS];
			yf_s2[l]    <= ys_s1[l][FRAC_BITS+7:FRAC_BITS];

			y_s3[l] <= full_swing ? yf_s2[l] : div255(lv_s2[l]) + 8'd16;
			y_s4[l] <= y_s3[l];
			y_s5[l] <= y_s4[l];
		end
		tb_s3 <= clamp_t(tb_sum);
		tr_s3 <= clamp_t(tr_sum);

		ub_s4 <= pb224[FRAC_BITS+16:FRAC_BITS+1];
		ur_s4 <= pr224[FRAC_BITS+16:FRAC_BITS+1];
		fb_s4 <= tb_s3[FRAC_BITS+8:FRAC_BITS+1];
		fr_s4 <= tr_s3[FRAC_BITS+8:FRAC_BITS+1];

		cb_s5 <= full_swing ? fb_s4 : div255(ub_s4) + 8'd16;
		cr_s5 <= full_swing ? fr_s4 : div255(ur_s4) + 8'd16;
	end

	assign res_push        = v_s5;
	assign res.luma_first  = y_s5[0];
	assign res.luma_second = pair_s5 ? y_s5[1] : 8'd0;
	assign res.chroma_blue = cb_s5;
	assign res.chroma_red  = cr_s5;
	assign res.alpha_out   = alpha_s5;

endmodule

>>> rtl/core/rgb_to_ycbcr_converter_unit.sv
// Top level of the RGB to YCbCr converter: config registers, job and result queues.
//
//  channel   handshake               payload
//  -------   ---------------------   -----------------------------------------
//  input     push / full             pixel  (red, green, blue, alpha, line_start)
//  result    pop / empty             result (luma_first, luma_second, chroma_*)
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  One pixel per clock while full stays low; 4:2:2 gives one result per two pixels.
//  After its last pixel is accepted, a result passes the job queue, the five-stage
//  conversion pipeline and the result queue write.
//  Reset: BT.709, limited range, 4:4:4, pairing cleared, both queues empty.
//  full rises when the job queue fills: once OUT_DEPTH results wait unread the
//  pipeline stops issuing, and MID_DEPTH more jobs then queue behind them.
`timescale 1ns / 1ps

module rgb_to_ycbcr_converter_unit #(
	parameter int FRAC_BITS = 16,
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rgbyc_pkg::pixel_in_t pixel,
	output logic                 full,
	input  logic                 pop,
	output rgbyc_pkg::result_t   result,
	output logic                 empty,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [1:0]           cfg_data
);

	localparam int JOB_W = $bits(rgbyc_pkg::job_t);
	localparam int RES_W = $bits(rgbyc_pkg::result_t);

	logic [1:0] colorimetry_q;
	logic       full_swing_q;
	logic       chroma_mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colorimetry_q <= rgbyc_pkg::CM_BT709;
			full_swing_q  <= 1'b0;
			chroma_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rgbyc_pkg::REG_COLORIMETRY: colorimetry_q <= cfg_data;
				rgbyc_pkg::REG_FULL_SWING:  full_swing_q  <= cfg_data[0];
				rgbyc_pkg::REG_CHROMA_MODE: chroma_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rgbyc_pkg::job_t    job_in;
	logic               job_push;
	logic               job_full;
	logic [JOB_W-1:0]   job_rdata;
	logic               job_empty;
	logic               job_pop;
	rgbyc_pkg::result_t res;
	logic               res_push;
	logic               res_full;
	logic [RES_W-1:0]   res_rdata;
	logic               drain;

	assign drain  = pop && !empty;
	assign result = rgbyc_pkg::result_t'(res_rdata);

	rgbyc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.pixel       (pixel),
		.full        (full),
		.chroma_mode (chroma_mode_q),
		.job_full    (job_full),
		.job_push    (job_push),
		.job         (job_in)
	);

	rgbyc_queue #(
		.WIDTH (JOB_W),
		.DEPTH (MID_DEPTH)
	) u_job_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_rdata),
		.empty  (job_empty)
	);

	rgbyc_back #(
		.FRAC_BITS (FRAC_BITS),
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.colorimetry (colorimetry_q),
		.full_swing  (full_swing_q),
		.job_valid   (!job_empty),
		.job         (rgbyc_pkg::job_t'(job_rdata)),
		.job_pop     (job_pop),
		.drain       (drain),
		.res_push    (res_push),
		.res         (res)
	);

	rgbyc_queue #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

`ifndef SYNTH
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_job_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !job_empty)
		else $error("job issued from an empty queue");

	a_single_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !chroma_mode_q) |=> !job_empty)
		else $error("4:4:4 item was not queued");
`endif

endmodule

>>> tb/rgb_to_ycbcr_converter_unit_test.sv
// Testbench for rgb_to_ycbcr_converter_unit: converter scoreboard, pixel and register stimulus.
`timescale 1ns / 1ps

module rgb_to_ycbcr_converter_unit_test;

	localparam int         FRAC_BITS     = 16;
	localparam int         SETTLE_CYCLES = 20;
	localparam int         QUIET_LIMIT   = 3000;
	localparam int         PHASES        = 16;
	localparam int         PHASE_ITEMS   = 68;
	localparam logic [1:0] REG_UNUSED    = 2'd3;
	localparam logic [1:0] CM_UNUSED     = 2'd3;

	class ycbcr_scoreboard;
		logic [1:0]         colorimetry;
		bit                 full_swing;
		bit                 chroma_mode;
		rgbyc_pkg::rgb_t    held_pixel;
		bit                 pair_open;
		rgbyc_pkg::result_t pending_ycbcr[$];
		int                 errors;

		function new();
			colorimetry = rgbyc_pkg::CM_BT709;
			full_swing  = 1'b0;
			chroma_mode = 1'b0;
			held_pixel  = '0;
			pair_open   = 1'b0;
			errors      = 0;
		endfunction

		function int pending();
			return pending_ycbcr.size();
		endfunction

		function void set_register(logic [1:0] idx, logic [1:0] val);
			case (idx)
				rgbyc_pkg::REG_COLORIMETRY: colorimetry = val;
				rgbyc_pkg::REG_FULL_SWING:  full_swing = val[0];
				rgbyc_pkg::REG_CHROMA_MODE: chroma_mode = val[0];
				default: ;
			endcase
		endfunction

		function longint fix_weight(longint w_e4);
			return (w_e4 * (longint'(1) <<< (FRAC_BITS + 1)) + 10000) / 20000;
		endfunction

		function longint fix_gain(longint w_e4);
			longint d;
			d = 10000 - w_e4;
			return (5000 * (longint'(1) <<< (FRAC_BITS + 1)) + d) / (2 * d);
		endfunction

		// luma in units of 1/(255*2^F), chroma floored toward minus infinity
		function void to_ycbcr(rgbyc_pkg::rgb_t px, output longint ys, output longint cb,
				output longint cr);
			longint wr_e4, wb_e4, wr, wb, wg, r, g, b;
			case (colorimetry)
				rgbyc_pkg::CM_BT601: begin
					wr_e4 = rgbyc_pkg::WR_E4_BT601;
					wb_e4 = rgbyc_pkg::WB_E4_BT601;
				end
				rgbyc_pkg::CM_BT2020: begin
					wr_e4 = rgbyc_pkg::WR_E4_BT2020;
					wb_e4 = rgbyc_pkg::WB_E4_BT2020;
				end
				default: begin
					wr_e4 = rgbyc_pkg::WR_E4_BT709;
					wb_e4 = rgbyc_pkg::WB_E4_BT709;
				end
			endcase
			r = px.red;
			g = px.green;
			b = px.blue;
			wr = fix_weight(wr_e4);
			wb = fix_weight(wb_e4);
			wg = (longint'(1) <<< FRAC_BITS) - wr - wb;
			ys = wr * r + wg * g + wb * b;
			cb = (((b <<< FRAC_BITS) - ys) * fix_gain(wb_e4)) >>> FRAC_BITS;
			cr = (((r <<< FRAC_BITS) - ys) * fix_gain(wr_e4)) >>> FRAC_BITS;
		endfunction

		function logic [7:0] luma_level(longint ys);
			if (full_swing)
				return 8'(ys >>> FRAC_BITS);
			return 8'((ys * 219) / (longint'(255) <<< FRAC_BITS) + 16);
		endfunction

		function logic [7:0] chroma_level(longint c1, longint c2);
			longint top, t;
			top = longint'(510) <<< FRAC_BITS;
			t = c1 + c2 + (longint'(255) <<< FRAC_BITS);
			if (t < 0)
				t = 0;
			if (t > top)
				t = top;
			if (full_swing)
				return 8'(t >>> (FRAC_BITS + 1));
			return 8'((t * 224) / top + 16);
		endfunction

		function void note_pixel(rgbyc_pkg::pixel_in_t p);
			rgbyc_pkg::rgb_t    cur;
			longint             ys1, cb1, cr1, ys2, cb2, cr2;
			rgbyc_pkg::result_t r;
			cur = {p.red, p.green, p.blue};
			if (!chroma_mode) begin
				pair_open = 1'b0;
				to_ycbcr(cur, ys1, cb1, cr1);
				r.luma_first  = luma_level(ys1);
				r.luma_second = 8'd0;
				r.chroma_blue = chroma_level(cb1, cb1);
				r.chroma_red  = chroma_level(cr1, cr1);
				r.alpha_out   = p.alpha;
				pending_ycbcr.push_back(r);
			end else if (p.line_start || !pair_open) begin
				held_pixel = cur;
				pair_open  = 1'b1;
			end else begin
				pair_open = 1'b0;
				to_ycbcr(held_pixel, ys1, cb1, cr1);
				to_ycbcr(cur, ys2, cb2, cr2);
				r.luma_first  = luma_level(ys1);
				r.luma_second = luma_level(ys2);
				r.chroma_blue = chroma_level(cb1, cb2);
				r.chroma_red  = chroma_level(cr1, cr2);
				r.alpha_out   = p.alpha;
				pending_ycbcr.push_back(r);
			end
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(rgbyc_pkg::result_t got);
			rgbyc_pkg::result_t want;
			if (pending_ycbcr.size() == 0) begin
				$error("result item with nothing pending: %h", got);
				errors++;
				return;
			end
			want = pending_ycbcr.pop_front();
			compare_field("luma_first", want.luma_first, got.luma_first);
			compare_field("luma_second", want.luma_second, got.luma_second);
			compare_field("chroma_blue", want.chroma_blue, got.chroma_blue);
			compare_field("chroma_red", want.chroma_red, got.chroma_red);
			compare_field("alpha_out", want.alpha_out, got.alpha_out);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 push;
	rgbyc_pkg::pixel_in_t pixel;
	logic                 full;
	logic                 pop;
	rgbyc_pkg::result_t   result;
	logic                 empty;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [1:0]           cfg_index;
	logic [1:0]           cfg_data;

	ycbcr_scoreboard sb = new();
	int  hold_cycles = 0;
	bit  calm = 1'b0;
	int  quiet = 0;

	rgb_to_ycbcr_converter_unit #(.FRAC_BITS(FRAC_BITS)) i_dut (
		.clk,
		.arst_n,
		.push,
		.pixel,
		.full,
		.pop,
		.result,
		.empty,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !arst_n) begin
			quiet = 0;
		end else begin
			quiet = quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("** rgb_to_ycbcr_converter_unit: FAILED **");
				$finish;
			end
		end
	end

	function automatic rgbyc_pkg::pixel_in_t pix(logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [7:0] a, logic ls);
		rgbyc_pkg::pixel_in_t p;
		p.red        = r;
		p.green      = g;
		p.blue       = b;
		p.alpha      = a;
		p.line_start = ls;
		return p;
	endfunction

	function automatic logic [7:0] rand_level();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic rgbyc_pkg::pixel_in_t rand_pixel(bit ls);
		return pix(rand_level(), rand_level(), rand_level(), 8'($urandom_range(0, 255)), ls);
	endfunction

	task automatic send(rgbyc_pkg::pixel_in_t p);
		push  <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (full);
		sb.note_pixel(p);
	endtask

	task automatic maybe_gap();
		if (!calm && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// stop offering pixels, let every expected item come back, then let the pipe settle
	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, val);
	endtask

	task automatic apply_settings(logic [1:0] cm, logic [1:0] fr, logic [1:0] mode);
		settle();
		write_reg(REG_UNUSED, 2'($urandom_range(0, 3)));
		write_reg(rgbyc_pkg::REG_COLORIMETRY, cm);
		write_reg(rgbyc_pkg::REG_FULL_SWING, fr);
		write_reg(rgbyc_pkg::REG_CHROMA_MODE, mode);
		cfg_valid <= 1'b0;
	endtask

	initial begin : receiver
		int stall;
		stall = 0;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				pop <= 1'b0;
				hold_cycles--;
			end else if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0)
					stall = $urandom_range(1, 9);
			end
			@(posedge clk);
			if (pop && !empty)
				sb.check_result(result);
		end
	end

	initial begin : stimulus
		bit ls;
		arst_n    <= 1'b0;
		push      <= 1'b0;
		pixel     <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= rgbyc_pkg::REG_COLORIMETRY;
		cfg_data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: BT.709, limited, 4:4:4
		send(pix(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		send(pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
		send(pix(8'hFF, 8'h00, 8'h00, 8'h55, 1'b0));
		send(pix(8'h00, 8'hFF, 8'h00, 8'hAA, 1'b1));
		send(pix(8'h00, 8'h00, 8'hFF, 8'h0F, 1'b0));

		apply_settings(rgbyc_pkg::CM_BT601, 2'd1, 2'd0);
		send(pix(8'hFF, 8'h00, 8'hFF, 8'hF0, 1'b0));
		send(pix(8'h00, 8'hFF, 8'hFF, 8'h01, 1'b0));
		send(pix(8'hFF, 8'hFF, 8'h00, 8'h80, 1'b1));
		send(pix(8'h00, 8'h00, 8'hFF, 8'h7F, 1'b0));
		send(pix(8'hFF, 8'h00, 8'h00, 8'hFE, 1'b0));

		apply_settings(rgbyc_pkg::CM_BT2020, 2'd0, 2'd1);
		send(pix(8'hFF, 8'h00, 8'h00, 8'h11, 1'b1));
		send(pix(8'h00, 8'h00, 8'hFF, 8'h22, 1'b0));
		// line start in the middle of a pair drops the held pixel
		send(pix(8'd10, 8'd20, 8'd30, 8'h33, 1'b1));
		send(pix(8'd200, 8'd100, 8'd50, 8'h44, 1'b1));
		send(pix(8'h00, 8'hFF, 8'h00, 8'h55, 1'b0));
		// odd line end, then a pair split by a settings change
		send(pix(8'd128, 8'd128, 8'd128, 8'h66, 1'b1));
		send(pix(8'd1, 8'd2, 8'd3, 8'h77, 1'b1));
		apply_settings(CM_UNUSED, 2'd1, 2'd1);
		send(pix(8'd254, 8'd1, 8'd127, 8'h88, 1'b0));
		// a 4:4:4 pixel clears the pairing
		send(pix(8'd7, 8'd8, 8'd9, 8'h99, 1'b1));
		apply_settings(CM_UNUSED, 2'd1, 2'd0);
		send(pix(8'hFF, 8'hFF, 8'hFF, 8'hAB, 1'b1));
		apply_settings(rgbyc_pkg::CM_BT709, 2'd0, 2'd1);
		send(pix(8'h00, 8'h00, 8'h00, 8'hCD, 1'b0));
		send(pix(8'hFF, 8'hFF, 8'hFF, 8'hEF, 1'b0));

		for (int p = 0; p < PHASES; p++) begin
			apply_settings(2'(p), {1'($urandom_range(0, 1)), 1'(p >> 2)},
				{1'($urandom_range(0, 1)), 1'(p >> 3)});
			if (p >= PHASES - 3)
				calm = 1'b1;
			if (p == 5)
				hold_cycles = 300;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 9 && i == PHASE_ITEMS / 2)
					settle();
				if (sb.chroma_mode)
					ls = ($urandom_range(0, 11) == 0);
				else
					ls = 1'($urandom_range(0, 1));
				send(rand_pixel(ls));
				maybe_gap();
			end
		end

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("** rgb_to_ycbcr_converter_unit: PASSED **");
		else
			$display("** rgb_to_ycbcr_converter_unit: FAILED **");
		$finish;
	end

endmodule
